// ===== sv/assert_macros.svh =====
// Assertion macros shared by the slot table smoother modules.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STES_CHECK_NOW(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define STES_CHECK_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== sv/stes_pkg.sv =====
// Types and constants for the slot table exponential smoother.
// No dependencies; used by every module of the block but stes_ram.
package stes_pkg;

  localparam int VALUE_W         = 24;
  localparam int HALF_W          = 25;
  localparam int HIGH_W          = 25;
  localparam int ALPHA_W         = 16;
  localparam int HOUR_W          = 5;
  localparam int MINUTE_W        = 6;

  localparam int HOURS_PER_DAY    = 24;
  localparam int MINUTES_PER_HOUR = 60;
  localparam int MINUTES_PER_SLOT = 15;
  localparam int SLOTS_PER_HOUR   = 4;

  localparam int ROUND_HALF      = 32768;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd19661;
  localparam logic [HIGH_W-1:0]  HIGH_MAX    = 25'd25165823;

  // 1.96 = 49/25, so the band test is (25*h)^2 * cnt <= (49*mean)^2.
  localparam int EST_SCALE     = 49;
  localparam int COUNT_SCALE   = 625;
  localparam int COUNT_SCALE_W = 10;
  localparam int SCALED_W      = 30;
  localparam int SQ_W          = 60;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_TIME = 1'b1;

  typedef enum logic [1:0] {
    ACT_OBSERVE = 2'd0,
    ACT_PREDICT = 2'd1,
    ACT_SEED    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef struct packed {
    action_t               action;
    logic [HOUR_W-1:0]     hour;
    logic [MINUTE_W-1:0]   minute;
    logic [VALUE_W-1:0]    sample_value;
  } in_req_t;

  typedef struct packed {
    logic                  status;
    logic [VALUE_W-1:0]    estimate;
    logic [VALUE_W-1:0]    band_low;
    logic [HIGH_W-1:0]     band_high;
  } out_rsp_t;

endpackage

// ===== sv/stes_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module stes_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/stes_band.sv =====
// Confidence band half-width unit: floor(1.96*mean/sqrt(count)), bit by bit.
// Depends on stes_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stes_band #(
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [stes_pkg::VALUE_W-1:0] est,
  input  logic [COUNT_BITS-1:0]        cnt,
  output logic                         done,
  output logic [stes_pkg::HALF_W-1:0]  half
);
  import stes_pkg::*;

  localparam int CW = COUNT_BITS + COUNT_SCALE_W;
  localparam int DW = CW + 2 * HALF_W;
  localparam int KW = $clog2(HALF_W);

  typedef enum logic [2:0] {
    B_IDLE   = 3'b001,
    B_SQUARE = 3'b010,
    B_ITER   = 3'b100
  } bstate_t;

  bstate_t             state_r, state_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic                done_r, done_nxt;
  logic [SCALED_W-1:0] e49_r, e49_nxt;
  logic [CW-1:0]       c_r, c_nxt;
  logic [SQ_W-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]       w_r, w_nxt;
  logic [DW-1:0]       v_r, v_nxt;
  logic [HALF_W-1:0]   h_r, h_nxt;
  logic [DW-1:0]       d;
  logic                take;

  // The remainder holds (49*mean)^2 - C*h^2; w is C*h scaled to the trial bit
  // and v is C*4^k, so one trial costs a single add and compare.
  assign d    = w_r + v_r;
  assign take = DW'(rem_r) >= d;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    done_nxt  = 1'b0;
    e49_nxt   = e49_r;
    c_nxt     = c_r;
    rem_nxt   = rem_r;
    w_nxt     = w_r;
    v_nxt     = v_r;
    h_nxt     = h_r;
    case (state_r)
      B_IDLE: begin
        if (go) begin
          e49_nxt   = SCALED_W'(est) * SCALED_W'(EST_SCALE);
          c_nxt     = CW'(cnt) * CW'(COUNT_SCALE);
          state_nxt = B_SQUARE;
        end
      end
      B_SQUARE: begin
        rem_nxt   = SQ_W'(e49_r) * SQ_W'(e49_r);
        w_nxt     = '0;
        v_nxt     = DW'(c_r) << (2 * (HALF_W - 1));
        h_nxt     = '0;
        k_nxt     = KW'(HALF_W - 1);
        state_nxt = B_ITER;
      end
      B_ITER: begin
        if (take) begin
          rem_nxt    = rem_r - d[SQ_W-1:0];
          w_nxt      = (w_r >> 1) + v_r;
          h_nxt[k_r] = 1'b1;
        end else begin
          w_nxt = w_r >> 1;
        end
        v_nxt = v_r >> 2;
        if (k_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = B_IDLE;
        end else begin
          k_nxt = k_r - KW'(1);
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    e49_r <= e49_nxt;
    c_r   <= c_nxt;
    rem_r <= rem_nxt;
    w_r   <= w_nxt;
    v_r   <= v_nxt;
    h_r   <= h_nxt;
  end

  assign done = done_r;
  assign half = h_r;

  `STES_CHECK_NOW(a_go_when_idle, go, state_r == B_IDLE, "band unit started while running")
  `STES_CHECK_NEXT(a_done_single, done_r, !done_r && state_r == B_IDLE, "done not a single pulse")

endmodule

// ===== sv/slot_table_exponential_smoother.sv =====
// Top level of the quarter-hour slot table with per-slot exponential smoothing.
// Depends on stes_pkg, stes_ram, stes_band and assert_macros.svh.
//
//   Channel  | Ports                     | Handshake
//   ---------+---------------------------+-----------------------------------
//   request  | start, busy, in_data      | taken when start high, busy low
//   result   | out_strobe, out_data      | one cycle, cannot be held off
//   config   | cfg_we, cfg_wdata         | written when cfg_we high
//
// Requests are handled one at a time. From the accepting edge busy stays high through the
// decode and finish states on clear, seed, a rejected or first observation and a prediction
// for an empty slot with no filled neighbour, through decode, read, write-back and finish on
// a smoothing observation, through decode, the slot or neighbour reads, band and finish on
// any other prediction, and also through the 25 trial steps of the band unit for a slot with
// two or more observations. The strobe comes as busy falls, when a new request can be taken.
// Synchronous active-low reset empties every slot and reloads the weight.
// The result side has no back-pressure, so nothing inside ever stalls.
`include "assert_macros.svh"

module slot_table_exponential_smoother #(
  parameter int SLOT_COUNT = 96,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  stes_pkg::in_req_t            in_data,
  output logic                         out_strobe,
  output stes_pkg::out_rsp_t           out_data,
  input  logic                         cfg_we,
  input  logic [stes_pkg::ALPHA_W-1:0] cfg_wdata
);
  import stes_pkg::*;

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int WORD_W = COUNT_BITS + VALUE_W;
  localparam int PROD_W = ALPHA_W + VALUE_W + 2;
  localparam logic [IDX_W-1:0]      LAST_SLOT = IDX_W'(SLOT_COUNT - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_TWO = COUNT_BITS'(2);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // One-hot sequencer. Each slot word in the RAM is {count, value}; the valid
  // bits live in flip-flops so that a clear empties the whole table at once.
  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_DECODE    = 10'b00_0000_0010,
    S_OBS_RD    = 10'b00_0000_0100,
    S_OBS_WB    = 10'b00_0000_1000,
    S_OWN_RD    = 10'b00_0001_0000,
    S_NBP_RD    = 10'b00_0010_0000,
    S_NBN_RD    = 10'b00_0100_0000,
    S_BAND      = 10'b00_1000_0000,
    S_BAND_WAIT = 10'b01_0000_0000,
    S_FIN       = 10'b10_0000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  in_req_t                 req_r, req_nxt;
  logic [IDX_W-1:0]        slot_r, slot_nxt;
  logic [IDX_W-1:0]        prev_r, prev_nxt;
  logic [IDX_W-1:0]        next_r, next_nxt;
  logic [VALUE_W-1:0]      est_r, est_nxt;
  logic [VALUE_W-1:0]      held_r, held_nxt;
  logic [COUNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [HALF_W-1:0]       half_r, half_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic                    status_r, status_nxt;
  logic [SLOT_COUNT-1:0]   valid_r, valid_nxt;
  logic [ALPHA_W-1:0]      alpha_r, alpha_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  out_rsp_t                out_data_r, out_data_nxt;

  logic                    ram_we;
  logic [WORD_W-1:0]       ram_wdata;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [WORD_W-1:0]       ram_rdata;
  logic [VALUE_W-1:0]      rd_value;
  logic [COUNT_BITS-1:0]   rd_count;

  logic                    band_go;
  logic                    band_done;
  logic [HALF_W-1:0]       band_half;

  logic [2:0]              quarter;
  logic [7:0]              slot_sum;
  logic [IDX_W-1:0]        in_slot;
  logic [IDX_W-1:0]        in_prev;
  logic [IDX_W-1:0]        in_next;
  logic                    bad_time;
  logic signed [VALUE_W:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]       acc;
  logic [VALUE_W-1:0]      new_value;
  logic [COUNT_BITS-1:0]   new_count;
  logic [VALUE_W:0]        pair_sum;
  logic [HALF_W:0]         hi_sum;
  logic [HIGH_W-1:0]       band_high;
  logic [VALUE_W-1:0]      band_low;

  // Slot of the incoming request: hour*4 plus the quarter of the hour, with
  // anything beyond the table pinned to the last slot. The neighbours wrap
  // round the day.
  always_comb begin
    quarter = 3'(in_data.minute >= MINUTE_W'(MINUTES_PER_SLOT))
            + 3'(in_data.minute >= MINUTE_W'(2 * MINUTES_PER_SLOT))
            + 3'(in_data.minute >= MINUTE_W'(3 * MINUTES_PER_SLOT))
            + 3'(in_data.minute >= MINUTE_W'(4 * MINUTES_PER_SLOT));
    slot_sum = 8'(in_data.hour) * 8'(SLOTS_PER_HOUR) + 8'(quarter);
    if (slot_sum >= 8'(SLOT_COUNT)) begin
      in_slot = LAST_SLOT;
    end else begin
      in_slot = IDX_W'(slot_sum);
    end
    in_prev = (in_slot == '0) ? LAST_SLOT : in_slot - IDX_W'(1);
    in_next = (in_slot == LAST_SLOT) ? '0 : in_slot + IDX_W'(1);
  end

  assign bad_time = (req_r.hour >= HOUR_W'(HOURS_PER_DAY)) ||
                    (req_r.minute >= MINUTE_W'(MINUTES_PER_HOUR));

  assign rd_value = ram_rdata[VALUE_W-1:0];
  assign rd_count = ram_rdata[WORD_W-1:VALUE_W];

  // Smoothing written as v + alpha*(x - v), so only one multiplier is needed.
  // The product is registered before the rounding add.
  assign diff      = $signed({1'b0, req_r.sample_value}) - $signed({1'b0, rd_value});
  assign prod      = $signed({1'b0, alpha_r}) * diff;
  assign acc       = {2'b00, held_r, {ALPHA_W{1'b0}}} + prod_r + PROD_W'(ROUND_HALF);
  assign new_value = acc[ALPHA_W +: VALUE_W];
  assign new_count = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_ONE;

  // Mean of two filled neighbours, rounded half up.
  assign pair_sum = {1'b0, held_r} + {1'b0, rd_value} + (VALUE_W + 1)'(1);

  // Band bounds: the upper one saturates, the lower one stops at zero.
  assign hi_sum    = {2'b00, est_r} + {1'b0, half_r};
  assign band_high = (hi_sum > {1'b0, HIGH_MAX}) ? HIGH_MAX : hi_sum[HIGH_W-1:0];
  assign band_low  = (half_r >= {1'b0, est_r}) ? '0 : est_r - half_r[VALUE_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    slot_nxt       = slot_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    est_nxt        = est_r;
    held_nxt       = held_r;
    cnt_nxt        = cnt_r;
    half_nxt       = half_r;
    prod_nxt       = prod_r;
    status_nxt     = status_r;
    valid_nxt      = valid_r;
    alpha_nxt      = cfg_we ? cfg_wdata : alpha_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_wdata      = {COUNT_ONE, req_r.sample_value};
    ram_re         = 1'b0;
    ram_raddr      = slot_r;
    band_go        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_data;
          slot_nxt   = in_slot;
          prev_nxt   = in_prev;
          next_nxt   = in_next;
          est_nxt    = '0;
          cnt_nxt    = '0;
          half_nxt   = '0;
          status_nxt = STATUS_OK;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (req_r.action)
          ACT_OBSERVE: begin
            if (bad_time) begin
              status_nxt = STATUS_BAD_TIME;
              state_nxt  = S_FIN;
            end else if (!valid_r[slot_r]) begin
              // First observation loads the raw sample.
              ram_we            = 1'b1;
              valid_nxt[slot_r] = 1'b1;
              state_nxt         = S_FIN;
            end else begin
              ram_re    = 1'b1;
              state_nxt = S_OBS_RD;
            end
          end
          ACT_PREDICT: begin
            if (valid_r[slot_r]) begin
              ram_re    = 1'b1;
              state_nxt = S_OWN_RD;
            end else if (valid_r[prev_r]) begin
              ram_re    = 1'b1;
              ram_raddr = prev_r;
              state_nxt = S_NBP_RD;
            end else if (valid_r[next_r]) begin
              ram_re    = 1'b1;
              ram_raddr = next_r;
              state_nxt = S_NBN_RD;
            end else begin
              state_nxt = S_FIN;
            end
          end
          ACT_SEED: begin
            ram_we            = 1'b1;
            valid_nxt[slot_r] = 1'b1;
            state_nxt         = S_FIN;
          end
          ACT_CLEAR: begin
            valid_nxt = '0;
            state_nxt = S_FIN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_OBS_RD: begin
        held_nxt  = rd_value;
        cnt_nxt   = rd_count;
        prod_nxt  = PROD_W'(prod);
        state_nxt = S_OBS_WB;
      end
      S_OBS_WB: begin
        ram_we    = 1'b1;
        ram_wdata = {new_count, new_value};
        state_nxt = S_FIN;
      end
      S_OWN_RD: begin
        est_nxt   = rd_value;
        cnt_nxt   = rd_count;
        state_nxt = S_BAND;
      end
      S_NBP_RD: begin
        if (valid_r[next_r]) begin
          held_nxt  = rd_value;
          ram_re    = 1'b1;
          ram_raddr = next_r;
          state_nxt = S_NBN_RD;
        end else begin
          est_nxt   = rd_value;
          state_nxt = S_BAND;
        end
      end
      S_NBN_RD: begin
        est_nxt   = valid_r[prev_r] ? pair_sum[VALUE_W:1] : rd_value;
        state_nxt = S_BAND;
      end
      S_BAND: begin
        // An empty slot carries count zero here, so it takes the plain half.
        if (cnt_r < COUNT_TWO) begin
          half_nxt  = HALF_W'(est_r >> 1);
          state_nxt = S_FIN;
        end else begin
          band_go   = 1'b1;
          state_nxt = S_BAND_WAIT;
        end
      end
      S_BAND_WAIT: begin
        if (band_done) begin
          half_nxt  = band_half;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        out_strobe_nxt         = 1'b1;
        out_data_nxt.status    = status_r;
        out_data_nxt.estimate  = est_r;
        out_data_nxt.band_low  = band_low;
        out_data_nxt.band_high = band_high;
        state_nxt              = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      alpha_r      <= ALPHA_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      alpha_r      <= alpha_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    slot_r     <= slot_nxt;
    prev_r     <= prev_nxt;
    next_r     <= next_nxt;
    est_r      <= est_nxt;
    held_r     <= held_nxt;
    cnt_r      <= cnt_nxt;
    half_r     <= half_nxt;
    prod_r     <= prod_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // Only one request is in flight, and every write lands before the next
  // request's read can be issued, so no forwarding path is needed.
  stes_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stes_band #(
    .COUNT_BITS (COUNT_BITS)
  ) u_band (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (band_go),
    .est   (est_r),
    .cnt   (cnt_r),
    .done  (band_done),
    .half  (band_half)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `STES_CHECK_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `STES_CHECK_NEXT(a_strobe_gap, out_strobe, !out_strobe, "two results in adjacent cycles")
  `STES_CHECK_NOW(a_band_order, out_strobe,
                  (out_data.band_low <= out_data.estimate) &&
                  (out_data.estimate <= out_data.band_high),
                  "band does not enclose the estimate")
  `STES_CHECK_NOW(a_bad_time_empty,
                  out_strobe && out_data.status == STATUS_BAD_TIME,
                  out_data.band_high == '0,
                  "rejected observation carries a band")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the quarter-hour slot table smoother.
// Depends on stes_pkg and slot_table_exponential_smoother, which brings in stes_ram and stes_band.

module tb_top;
  import stes_pkg::*;

  localparam int NSLOTS       = 96;
  localparam int NCOUNT_BITS  = 16;
  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 11;
  localparam int QUIET_LIMIT  = 2000;  // far above the longest busy stretch plus sender gaps
  localparam int TAIL_CYCLES  = 40;    // outlasts the longest busy stretch
  localparam int SEG_ITEMS    = 135;
  localparam int BURST_OBS    = 24;    // enough observations to lift a count well past two
  localparam bit [NCOUNT_BITS-1:0] COUNT_CEIL = '1;

  // One row of the directed table. Where typed is set, rsp is the result read
  // straight off the specification; otherwise the predictor supplies it.
  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_req_t  in_data = '0;
  logic     out_strobe;
  out_rsp_t out_data;
  logic     cfg_we = 1'b0;
  logic [ALPHA_W-1:0] cfg_wdata = '0;

  // Predictor's own copy of the table and of the weight register.
  bit [VALUE_W-1:0]     tbl_value [NSLOTS];
  bit [NCOUNT_BITS-1:0] tbl_count [NSLOTS];
  bit                   tbl_valid [NSLOTS];
  bit [ALPHA_W-1:0]     alpha_q16;

  out_rsp_t pending_results [$];
  out_rsp_t oldest_result;
  bit       typed_valid = 1'b0;
  out_rsp_t typed_rsp = '0;
  int       sender_idle_pct = 0;
  int       fail_count = 0;
  int       quiet_cycles = 0;
  bit       request_taken;

  stim_row_t directed_rows [25];

  slot_table_exponential_smoother #(
    .SLOT_COUNT (NSLOTS),
    .COUNT_BITS (NCOUNT_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Floor of the square root, built up one result bit at a time. The argument
  // stays below 2^60, so the root fits in 30 bits and each trial square fits.
  function automatic bit [63:0] floor_root(bit [63:0] v);
    bit [63:0] root;
    bit [63:0] trial;
    int        b;
    root = '0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Applies one request to the predictor's table and returns the result the
  // block ought to give for it.
  function automatic out_rsp_t predict_slot_table(in_req_t r);
    out_rsp_t  res;
    int        slot;
    int        nb_prev;
    int        nb_next;
    bit [63:0] mean;
    bit [63:0] cnt;
    bit [63:0] half;
    bit [63:0] acc;
    bit [63:0] upper;
    res  = '0;
    mean = '0;
    cnt  = '0;
    slot = int'(r.hour) * SLOTS_PER_HOUR + int'(r.minute) / MINUTES_PER_SLOT;
    if (slot > NSLOTS - 1) slot = NSLOTS - 1;
    case (r.action)
      ACT_OBSERVE: begin
        if (r.hour >= HOURS_PER_DAY || r.minute >= MINUTES_PER_HOUR) begin
          res.status = STATUS_BAD_TIME;
        end else if (!tbl_valid[slot]) begin
          tbl_value[slot] = r.sample_value;
          tbl_count[slot] = 1;
          tbl_valid[slot] = 1'b1;
        end else begin
          acc = 64'(alpha_q16) * 64'(r.sample_value)
              + (64'd65536 - 64'(alpha_q16)) * 64'(tbl_value[slot]) + 64'(ROUND_HALF);
          tbl_value[slot] = acc[16 +: VALUE_W];
          if (tbl_count[slot] != COUNT_CEIL) tbl_count[slot] = tbl_count[slot] + 1'b1;
        end
      end
      ACT_PREDICT: begin
        if (tbl_valid[slot]) begin
          mean = 64'(tbl_value[slot]);
          cnt  = 64'(tbl_count[slot]);
        end else begin
          // An empty slot borrows from its neighbours, wrapping round midnight.
          nb_prev = (slot == 0) ? NSLOTS - 1 : slot - 1;
          nb_next = (slot == NSLOTS - 1) ? 0 : slot + 1;
          if (tbl_valid[nb_prev] && tbl_valid[nb_next])
            mean = (64'(tbl_value[nb_prev]) + 64'(tbl_value[nb_next]) + 64'd1) >> 1;
          else if (tbl_valid[nb_prev])
            mean = 64'(tbl_value[nb_prev]);
          else if (tbl_valid[nb_next])
            mean = 64'(tbl_value[nb_next]);
        end
        // 1.96 * mean / sqrt(count) is taken exactly as sqrt(2401 * mean^2 / (625 * count)).
        if (cnt < 2) half = mean >> 1;
        else half = floor_root((64'd2401 * mean * mean) / (64'd625 * cnt));
        upper = mean + half;
        if (upper > 64'(HIGH_MAX)) upper = 64'(HIGH_MAX);
        res.estimate  = mean[VALUE_W-1:0];
        res.band_low  = (half >= mean) ? '0 : VALUE_W'(mean - half);
        res.band_high = upper[HIGH_W-1:0];
      end
      ACT_SEED: begin
        tbl_value[slot] = r.sample_value;
        tbl_count[slot] = 1;
        tbl_valid[slot] = 1'b1;
      end
      default: begin
        // Clear drops the valid bits only; values and counts are left behind.
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      end
    endcase
    return res;
  endfunction

  function automatic stim_row_t stim_row(action_t act, int hr, int mn, int smp, bit typed,
                                         int st, int est, int lo, int hi);
    stim_row_t row;
    row.req.action       = act;
    row.req.hour         = hr[HOUR_W-1:0];
    row.req.minute       = mn[MINUTE_W-1:0];
    row.req.sample_value = smp[VALUE_W-1:0];
    row.typed            = typed;
    row.rsp.status       = st[0];
    row.rsp.estimate     = est[VALUE_W-1:0];
    row.rsp.band_low     = lo[VALUE_W-1:0];
    row.rsp.band_high    = hi[HIGH_W-1:0];
    return row;
  endfunction

  // Random request. Most times land in a small window round a focus slot so
  // that slots fill up, smooth several times and leave empty neighbours to be
  // averaged; the rest spread over the day or use raw field values, which
  // also brings in hours and minutes that an observation must reject.
  function automatic in_req_t random_request(int focus);
    in_req_t r;
    int      pick;
    int      slot;
    pick = $urandom_range(99);
    if (pick < 42)      r.action = ACT_OBSERVE;
    else if (pick < 80) r.action = ACT_PREDICT;
    else if (pick < 97) r.action = ACT_SEED;
    else                r.action = ACT_CLEAR;
    pick = $urandom_range(99);
    if (pick < 8) begin
      r.hour   = HOUR_W'($urandom_range(31));
      r.minute = MINUTE_W'($urandom_range(63));
    end else begin
      if (pick < 75) slot = (focus + int'($urandom_range(6)) - 3 + NSLOTS) % NSLOTS;
      else slot = $urandom_range(NSLOTS - 1);
      r.hour   = HOUR_W'(slot / SLOTS_PER_HOUR);
      r.minute = MINUTE_W'((slot % SLOTS_PER_HOUR) * MINUTES_PER_SLOT + $urandom_range(14));
    end
    case ($urandom_range(9))
      0:       r.sample_value = '0;
      1:       r.sample_value = '1;
      2, 3, 4: r.sample_value = VALUE_W'($urandom_range(16'hFFFF));
      default: r.sample_value = VALUE_W'($urandom);
    endcase
    return r;
  endfunction

  // Presents one request from a falling edge and holds it until the block
  // takes it. Each falling edge sees at most one assignment to start, so a
  // back-to-back request simply keeps start high.
  task automatic send_request(in_req_t r, bit typed, out_rsp_t rsp);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    in_data     <= r;
    typed_valid <= typed;
    typed_rsp   <= rsp;
    do @(posedge clk); while (busy);
  endtask

  // Stops sending and waits for every outstanding result. Every request gives
  // exactly one result in the cycle busy falls, so the block is idle after.
  task automatic drain_requests();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_weight(bit [ALPHA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic report_field(string field, bit [63:0] want, bit [63:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  // Everything is sampled on the rising edge: results are checked against the
  // oldest expectation first, then a request taken at this edge is run through
  // the predictor. Both can happen at one edge, since the block takes the next
  // request in the cycle its result appears.
  always @(posedge clk) begin
    if (!rst_n) begin
      alpha_q16 = ALPHA_RESET;
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    end else begin
      request_taken = start && !busy;
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual 0x%0h", $time, out_data);
        end else begin
          oldest_result = pending_results.pop_front();
          if (out_data.status !== oldest_result.status)
            report_field("status", 64'(oldest_result.status), 64'(out_data.status));
          if (out_data.estimate !== oldest_result.estimate)
            report_field("estimate", 64'(oldest_result.estimate), 64'(out_data.estimate));
          if (out_data.band_low !== oldest_result.band_low)
            report_field("band_low", 64'(oldest_result.band_low), 64'(out_data.band_low));
          if (out_data.band_high !== oldest_result.band_high)
            report_field("band_high", 64'(oldest_result.band_high), 64'(out_data.band_high));
        end
      end
      if (request_taken) begin
        oldest_result = predict_slot_table(in_data);
        pending_results.push_back(typed_valid ? typed_rsp : oldest_result);
      end
      if (cfg_we) alpha_q16 = cfg_wdata;

      // Watchdog: a hang shows as a long run of edges with nothing moving.
      if (request_taken || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no request or result for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int               seg;
    int               focus;
    in_req_t          burst_req;
    bit [ALPHA_W-1:0] seg_weight;

    // Directed table, run under the reset weight. The first rows hit an empty
    // table, rejected times and a first observation; later ones reach the
    // neighbour average across the wrap, a lone filled neighbour on either side,
    // the clamped last slot, a clear, and the band for counts of two or more.
    directed_rows = '{
      stim_row(ACT_PREDICT,  0,  0, 0,         1, 0, 0, 0, 0),
      stim_row(ACT_OBSERVE, 24,  0, 5,         1, 1, 0, 0, 0),
      stim_row(ACT_OBSERVE,  0, 60, 7,         1, 1, 0, 0, 0),
      stim_row(ACT_OBSERVE, 31, 63, 'hFFFFFF,  1, 1, 0, 0, 0),
      stim_row(ACT_OBSERVE,  0,  0, 'h000400,  1, 0, 0, 0, 0),
      stim_row(ACT_PREDICT,  0, 14, 0,         1, 0, 'h400, 'h200, 'h600),
      stim_row(ACT_OBSERVE,  0,  5, 'h000800,  0, 0, 0, 0, 0),
      stim_row(ACT_PREDICT,  0,  0, 0,         0, 0, 0, 0, 0),
      stim_row(ACT_PREDICT,  0, 15, 0,         0, 0, 0, 0, 0),
      stim_row(ACT_SEED,    23, 59, 'hFFFFFF,  1, 0, 0, 0, 0),
      stim_row(ACT_PREDICT,  0, 30, 0,         1, 0, 0, 0, 0),
      stim_row(ACT_PREDICT, 23, 44, 0,         1, 0, 'hFFFFFF, 'h800000, 'h17FFFFE),
      stim_row(ACT_PREDICT, 31, 63, 0,         1, 0, 'hFFFFFF, 'h800000, 'h17FFFFE),
      stim_row(ACT_CLEAR,   31, 63, 'hFFFFFF,  1, 0, 0, 0, 0),
      stim_row(ACT_SEED,     0, 15, 'h000100,  1, 0, 0, 0, 0),
      stim_row(ACT_SEED,    23, 45, 'h000301,  1, 0, 0, 0, 0),
      stim_row(ACT_PREDICT,  0,  0, 0,         0, 0, 0, 0, 0),
      stim_row(ACT_PREDICT, 23, 30, 0,         0, 0, 0, 0, 0),
      stim_row(ACT_PREDICT,  0, 30, 0,         0, 0, 0, 0, 0),
      stim_row(ACT_OBSERVE,  0, 15, 'hFFFFFF,  0, 0, 0, 0, 0),
      stim_row(ACT_OBSERVE,  0, 29, 'hFFFFFF,  0, 0, 0, 0, 0),
      stim_row(ACT_PREDICT,  0, 15, 0,         0, 0, 0, 0, 0),
      stim_row(ACT_OBSERVE,  0, 15, 0,         0, 0, 0, 0, 0),
      stim_row(ACT_PREDICT,  0, 16, 0,         0, 0, 0, 0, 0),
      stim_row(ACT_SEED,    31, 63, 0,         1, 0, 0, 0, 0)
    };

    // Synchronous reset held low from the start, then released once at a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 11;
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

    // Random segments. Each one starts from an idle block, so the weight can
    // be rewritten there; the settings take in both ends of the range and the
    // zero weight, under which a filled slot must not move. The sender's idle
    // chance is 11 percent first, then 59, then zero.
    for (seg = 0; seg < 6; seg++) begin
      drain_requests();
      case (seg)
        0:       seg_weight = 16'd1;
        1:       seg_weight = 16'hFFFF;
        3:       seg_weight = 16'd0;
        4:       seg_weight = 16'h8000;
        default: seg_weight = ALPHA_W'($urandom_range(1, 16'hFFFF));
      endcase
      write_weight(seg_weight);
      sender_idle_pct = (seg < 2) ? 11 : (seg < 4) ? 59 : 0;
      case (seg)
        0:       focus = 0;
        1:       focus = NSLOTS - 1;
        default: focus = $urandom_range(NSLOTS - 1);
      endcase
      repeat (SEG_ITEMS) send_request(random_request(focus), 1'b0, '0);
    end

    // Long run on one slot: it is seeded and then observed many times in a
    // row, after which a prediction exercises the band at a high count.
    drain_requests();
    write_weight(ALPHA_RESET);
    burst_req.action       = ACT_SEED;
    burst_req.hour         = HOUR_W'(10);
    burst_req.minute       = '0;
    burst_req.sample_value = VALUE_W'($urandom);
    send_request(burst_req, 1'b0, '0);
    burst_req.action = ACT_OBSERVE;
    repeat (BURST_OBS) begin
      burst_req.minute       = MINUTE_W'($urandom_range(14));
      burst_req.sample_value = VALUE_W'($urandom);
      send_request(burst_req, 1'b0, '0);
    end
    burst_req.action = ACT_PREDICT;
    send_request(burst_req, 1'b0, '0);

    // Wind down: wait for every result, then give any stray result time to
    // show before the verdict is taken away from the rising edge.
    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== slot_table_exponential_smoother.f =====
+incdir+sv
sv/stes_pkg.sv
sv/stes_ram.sv
sv/stes_band.sv
sv/slot_table_exponential_smoother.sv
dv/tb_top.sv
